@@ rtl/core/qph_pkg.sv @@
// Shared types, codes and sizes for the quadratic probe hash table.
package qph_pkg;

  localparam int TableDepth = 1024;
  localparam int AddrW      = $clog2(TableDepth);
  localparam int SizeW      = AddrW + 1;
  localparam int CfgW       = 11;
  localparam int KeyW       = 32;
  localparam int DataW      = 32;
  localparam int ValueW     = 32;

  localparam logic [CfgW-1:0] SizeReset = CfgW'(997);

  // Remainder unit: quotient bits retired per cycle
  localparam int ModBits   = 4;
  localparam int ModCycles = KeyW / ModBits;
  localparam int ModCntW   = $clog2(ModCycles);

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_LOOKUP = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  localparam logic [2:0] ST_INSERTED  = 3'd0;
  localparam logic [2:0] ST_DUPLICATE = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_FOUND     = 3'd3;
  localparam logic [2:0] ST_NOT_FOUND = 3'd4;
  localparam logic [2:0] ST_CLEARED   = 3'd5;

  typedef struct packed {
    logic [1:0]      operation;
    logic [KeyW-1:0] key;
    logic [DataW-1:0] value;
  } req_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [DataW-1:0] found_value;
  } rsp_t;

  typedef struct packed {
    logic              filled;
    logic [KeyW-1:0]   key;
    logic [ValueW-1:0] value;
  } ent_t;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_MOD,
    S_PROBE,
    S_CLEAR,
    S_DONE
  } state_t;

endpackage

@@ rtl/core/qph_mod.sv @@
// Iterative remainder unit: key modulo table size, several bits per cycle.
module qph_mod (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [qph_pkg::KeyW-1:0]    dividend,
  input  logic [qph_pkg::SizeW-1:0]   divisor,
  output logic                        done,
  output logic [qph_pkg::AddrW-1:0]   remainder
);

  logic                         busy;
  logic [qph_pkg::ModCntW-1:0]  cnt;
  logic [qph_pkg::KeyW-1:0]     dvd;
  logic [qph_pkg::AddrW-1:0]    rem_next;

  // restoring steps, MSB first; partial remainder stays below divisor
  always_comb begin
    logic [qph_pkg::SizeW-1:0] t;
    logic [qph_pkg::AddrW-1:0] r;
    r = remainder;
    for (int i = 0; i < qph_pkg::ModBits; i++) begin
      t = {r, dvd[qph_pkg::KeyW-1-i]};
      if (t >= divisor) begin
        r = qph_pkg::AddrW'(t - divisor);
      end else begin
        r = t[qph_pkg::AddrW-1:0];
      end
    end
    rem_next = r;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= !start && busy && (cnt == qph_pkg::ModCntW'(qph_pkg::ModCycles - 1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == qph_pkg::ModCntW'(qph_pkg::ModCycles - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      remainder <= '0;
      dvd       <= dividend;
    end else if (busy) begin
      remainder <= rem_next;
      dvd       <= dvd << qph_pkg::ModBits;
    end
  end

endmodule

@@ rtl/core/quadratic_probe_hash_table.sv @@
// Top level: open-addressing hash table with quadratic probing in one slot memory.
//
//   channel  | handshake             | payload
//   ---------+-----------------------+--------------------------------------
//   in       | in_valid / in_ready   | in_data  : operation, key, value
//   out      | out_valid / out_ready | out_data : status, found_value
//   cfg      | cfg_valid / cfg_ready | cfg_data : table_size (always ready)
//
// Insert/lookup: the beat is accepted, the remainder unit reduces key mod size (4 bits
// a cycle, then a registered done flag), then one probe per cycle (up to size/2 + 2
// probes), then the result is posted once out is free. Clear rewrites all TableDepth
// (1024) slots, one a cycle; after reset the same sweep runs before in_ready rises.
// One item at a time; a new beat is taken while the last result waits on out.
module quadratic_probe_hash_table (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  qph_pkg::req_t              in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output qph_pkg::rsp_t              out_data,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [qph_pkg::CfgW-1:0]   cfg_data
);

  qph_pkg::state_t state, state_next;

  logic [qph_pkg::CfgW-1:0]   table_size;
  logic [qph_pkg::SizeW-1:0]  n_eff;
  logic [qph_pkg::AddrW-1:0]  n_half;

  qph_pkg::req_t              req;
  qph_pkg::rsp_t              res, res_next;
  logic                       res_load;

  logic [qph_pkg::AddrW-1:0]  pos, step, cnt;
  logic [qph_pkg::AddrW-1:0]  pos_adv, step_adv;
  logic [qph_pkg::AddrW-1:0]  clr_addr;
  logic                       clr_last;

  logic                       mod_start, mod_done;
  logic [qph_pkg::AddrW-1:0]  mod_rem;

  qph_pkg::ent_t              mem [qph_pkg::TableDepth];
  qph_pkg::ent_t              rdata, wdata;
  logic [qph_pkg::AddrW-1:0]  raddr, waddr;
  logic                       we;

  logic                       hit_filled, hit_match, cont;
  logic                       in_beat, post;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == qph_pkg::S_IDLE);
  assign in_beat   = in_valid && in_ready;
  assign post      = !out_valid || out_ready;
  assign clr_last  = (clr_addr == qph_pkg::AddrW'(qph_pkg::TableDepth - 1));

  // effective size, clamped to 2 .. depth
  always_comb begin
    if (table_size < qph_pkg::CfgW'(2)) begin
      n_eff = qph_pkg::SizeW'(2);
    end else if (int'(table_size) > qph_pkg::TableDepth) begin
      n_eff = qph_pkg::SizeW'(qph_pkg::TableDepth);
    end else begin
      n_eff = qph_pkg::SizeW'(table_size);
    end
  end
  assign n_half = n_eff[qph_pkg::SizeW-1:1];

  // next probe position and step, both kept reduced mod size
  always_comb begin
    logic [qph_pkg::SizeW-1:0] sum, st2;
    sum = {1'b0, pos} + {1'b0, step};
    st2 = {1'b0, step} + qph_pkg::SizeW'(2);
    pos_adv  = (sum >= n_eff) ? qph_pkg::AddrW'(sum - n_eff) : sum[qph_pkg::AddrW-1:0];
    step_adv = (st2 >= n_eff) ? qph_pkg::AddrW'(st2 - n_eff) : st2[qph_pkg::AddrW-1:0];
  end

  assign hit_filled = rdata.filled;
  assign hit_match  = (rdata.key == req.key);
  assign cont       = hit_filled && !hit_match && (cnt <= n_half);

  qph_mod u_mod (
    .clk       (clk),
    .rst       (rst),
    .start     (mod_start),
    .dividend  (in_data.key),
    .divisor   (n_eff),
    .done      (mod_done),
    .remainder (mod_rem)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      qph_pkg::S_INIT: begin
        if (clr_last) state_next = qph_pkg::S_IDLE;
      end
      qph_pkg::S_IDLE: begin
        if (in_beat) begin
          if (in_data.operation == qph_pkg::OP_CLEAR) begin
            state_next = qph_pkg::S_CLEAR;
          end else if (in_data.operation inside {qph_pkg::OP_INSERT, qph_pkg::OP_LOOKUP}) begin
            state_next = qph_pkg::S_MOD;
          end else begin
            state_next = qph_pkg::S_DONE;
          end
        end
      end
      qph_pkg::S_MOD: begin
        if (mod_done) state_next = qph_pkg::S_PROBE;
      end
      qph_pkg::S_PROBE: begin
        if (!cont) state_next = qph_pkg::S_DONE;
      end
      qph_pkg::S_CLEAR: begin
        if (clr_last) state_next = qph_pkg::S_DONE;
      end
      qph_pkg::S_DONE: begin
        if (post) state_next = qph_pkg::S_IDLE;
      end
      default: state_next = qph_pkg::S_INIT;
    endcase
  end

  // memory control and result
  always_comb begin
    mod_start = 1'b0;
    we        = 1'b0;
    waddr     = clr_addr;
    wdata     = '0;
    raddr     = pos_adv;
    res_load  = 1'b0;
    res_next  = '{status: qph_pkg::ST_NOT_FOUND, found_value: '0};
    case (state)
      qph_pkg::S_INIT: begin
        we = 1'b1;
      end
      qph_pkg::S_IDLE: begin
        mod_start = in_beat && (in_data.operation inside {qph_pkg::OP_INSERT, qph_pkg::OP_LOOKUP});
        res_load  = in_beat;
      end
      qph_pkg::S_MOD: begin
        raddr = mod_rem;
      end
      qph_pkg::S_PROBE: begin
        if (!cont) begin
          res_load = 1'b1;
          if (req.operation == qph_pkg::OP_INSERT) begin
            if (!hit_filled) begin
              we              = 1'b1;
              waddr           = pos;
              wdata.filled    = 1'b1;
              wdata.key       = req.key;
              wdata.value     = qph_pkg::ValueW'(req.value);
              res_next.status = qph_pkg::ST_INSERTED;
            end else if (hit_match) begin
              res_next.status = qph_pkg::ST_DUPLICATE;
            end else begin
              res_next.status = qph_pkg::ST_FULL;
            end
          end else if (hit_filled && hit_match) begin
            res_next.status      = qph_pkg::ST_FOUND;
            res_next.found_value = qph_pkg::DataW'(rdata.value);
          end
        end
      end
      qph_pkg::S_CLEAR: begin
        we = 1'b1;
        if (clr_last) begin
          res_load        = 1'b1;
          res_next.status = qph_pkg::ST_CLEARED;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= qph_pkg::S_INIT;
      clr_addr   <= '0;
      out_valid  <= 1'b0;
      table_size <= qph_pkg::SizeReset;
    end else begin
      state <= state_next;
      if (state inside {qph_pkg::S_INIT, qph_pkg::S_CLEAR}) begin
        clr_addr <= clr_last ? '0 : clr_addr + 1'b1;
      end
      if (cfg_valid && cfg_ready) begin
        table_size <= cfg_data;
      end
      if (state == qph_pkg::S_DONE && post) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      req <= in_data;
    end
    if (res_load) begin
      res <= res_next;
    end
    if (state == qph_pkg::S_DONE && post) begin
      out_data <= res;
    end
    if (state == qph_pkg::S_MOD && mod_done) begin
      pos  <= mod_rem;
      step <= qph_pkg::AddrW'(1);
      cnt  <= '0;
    end else if (state == qph_pkg::S_PROBE && cont) begin
      pos  <= pos_adv;
      step <= step_adv;
      cnt  <= cnt + 1'b1;
    end
  end

endmodule

@@ dv/tb.sv @@
// Self-checking bench for the quadratic probe hash table: directed rows, then random phases.
module tb;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int HoldCycles = 400;
  localparam int DrainCycles = 60;
  localparam int RandomItems = 660;

  typedef struct {
    bit                       is_cfg;
    logic [qph_pkg::CfgW-1:0] size;
    qph_pkg::req_t            req;
    bit                       typed;
    qph_pkg::rsp_t            rsp;
  } row_t;

  logic                     clk;
  logic                     rst;
  logic                     in_valid;
  logic                     in_ready;
  qph_pkg::req_t            in_data;
  logic                     out_valid;
  logic                     out_ready;
  qph_pkg::rsp_t            out_data;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [qph_pkg::CfgW-1:0] cfg_data;

  // typed expectation travels with the beat it belongs to
  bit            cur_typed;
  qph_pkg::rsp_t cur_typed_rsp;

  bit no_idle;
  bit hold_out;

  // shadow of the table
  logic [qph_pkg::CfgW-1:0]  size_reg = qph_pkg::SizeReset;
  logic                      slot_used [qph_pkg::TableDepth];
  logic [qph_pkg::KeyW-1:0]  slot_key  [qph_pkg::TableDepth];
  logic [qph_pkg::DataW-1:0] slot_val  [qph_pkg::TableDepth];

  qph_pkg::rsp_t            pending_rsp [$];
  row_t                     plan [$];
  logic [qph_pkg::KeyW-1:0] key_pool [$];
  int unsigned bad_count;
  int unsigned beats_checked;
  int unsigned sizes_written;
  int unsigned status_seen [6];

  quadratic_probe_hash_table u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #40_000_000;
    $display("tb failed");
    $finish;
  end

  function automatic int unsigned clamp_size(logic [qph_pkg::CfgW-1:0] sz);
    int unsigned n;
    n = sz;
    if (n < 2) n = 2;
    if (n > qph_pkg::TableDepth) n = qph_pkg::TableDepth;
    return n;
  endfunction

  // Applies one operation to the shadow table and returns its result.
  function automatic qph_pkg::rsp_t apply_op(qph_pkg::req_t r);
    qph_pkg::rsp_t res;
    int unsigned   n;
    int unsigned   pos;
    int unsigned   step;
    int unsigned   cnt;
    n = clamp_size(size_reg);
    res.status = qph_pkg::ST_NOT_FOUND;
    res.found_value = '0;
    case (r.operation)
      qph_pkg::OP_INSERT, qph_pkg::OP_LOOKUP: begin
        pos = r.key % n;
        step = 1;
        cnt = 0;
        while (slot_used[pos] && slot_key[pos] != r.key && cnt <= n / 2) begin
          cnt++;
          pos = (pos + step) % n;
          step += 2;
        end
        if (r.operation == qph_pkg::OP_INSERT) begin
          if (!slot_used[pos]) begin
            slot_used[pos] = 1'b1;
            slot_key[pos] = r.key;
            slot_val[pos] = r.value;
            res.status = qph_pkg::ST_INSERTED;
          end else if (slot_key[pos] == r.key) begin
            res.status = qph_pkg::ST_DUPLICATE;
          end else begin
            res.status = qph_pkg::ST_FULL;
          end
        end else if (slot_used[pos] && slot_key[pos] == r.key) begin
          res.status = qph_pkg::ST_FOUND;
          res.found_value = slot_val[pos];
        end
      end
      qph_pkg::OP_CLEAR: begin
        for (int i = 0; i < qph_pkg::TableDepth; i++) slot_used[i] = 1'b0;
        res.status = qph_pkg::ST_CLEARED;
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (no_idle || p < 55) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void plan_cfg(logic [qph_pkg::CfgW-1:0] sz);
    row_t r;
    r.is_cfg = 1'b1;
    r.size = sz;
    r.req = '0;
    r.typed = 1'b0;
    r.rsp = '0;
    plan.push_back(r);
  endfunction

  function automatic void plan_op(logic [1:0] op, logic [qph_pkg::KeyW-1:0] k,
                                  logic [qph_pkg::DataW-1:0] v, bit typed, logic [2:0] st,
                                  logic [qph_pkg::DataW-1:0] fv);
    row_t r;
    r.is_cfg = 1'b0;
    r.size = '0;
    r.req.operation = op;
    r.req.key = k;
    r.req.value = v;
    r.typed = typed;
    r.rsp.status = st;
    r.rsp.found_value = fv;
    plan.push_back(r);
  endfunction

  // row checked against the shadow table only
  function automatic void plan_pred(logic [1:0] op, logic [qph_pkg::KeyW-1:0] k,
                                    logic [qph_pkg::DataW-1:0] v);
    plan_op(op, k, v, 1'b0, qph_pkg::ST_NOT_FOUND, '0);
  endfunction

  // Called at a rising edge (or at start); returns at the edge that takes the beat.
  task automatic send_item(qph_pkg::req_t r, bit typed, qph_pkg::rsp_t rsp);
    int unsigned g;
    g = pick_gap();
    @(negedge clk);
    if (g != 0) begin
      in_valid = 1'b0;
      repeat (g) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = r;
    cur_typed = typed;
    cur_typed_rsp = rsp;
    do @(posedge clk); while (!in_ready);
  endtask

  // Size writes only once every result is back, so the block is idle.
  task automatic write_size(logic [qph_pkg::CfgW-1:0] sz);
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_rsp.size() != 0) @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data = sz;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
    sizes_written++;
  endtask

  always @(posedge clk) begin
    qph_pkg::rsp_t want;
    qph_pkg::rsp_t got;
    if (!rst) begin
      if (cfg_valid && cfg_ready) size_reg = cfg_data;
      if (in_valid && in_ready) begin
        want = apply_op(in_data);
        if (cur_typed) want = cur_typed_rsp;
        pending_rsp.push_back(want);
      end
      if (out_valid && out_ready) begin
        got = out_data;
        if (pending_rsp.size() == 0) begin
          $display("%0t: result beat with nothing pending: status %0d value %h",
                   $time, got.status, got.found_value);
          bad_count++;
        end else begin
          want = pending_rsp.pop_front();
          beats_checked++;
          if (got.status !== want.status) begin
            $display("%0t: status expected %0d got %0d", $time, want.status, got.status);
            bad_count++;
          end
          if (got.found_value !== want.found_value) begin
            $display("%0t: found_value expected %h got %h", $time, want.found_value,
                     got.found_value);
            bad_count++;
          end
          if (got.status < 6) status_seen[got.status]++;
        end
      end
    end
  end

  // Result side: random back-pressure, plus one long hold on request.
  initial begin
    int unsigned g;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_out) begin
        hold_out = 1'b0;
        out_ready = 1'b0;
        repeat (HoldCycles) @(negedge clk);
      end
      g = pick_gap();
      if (g != 0) begin
        out_ready = 1'b0;
        repeat (g) @(negedge clk);
      end
      out_ready = 1'b1;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
  end

  initial begin
    qph_pkg::req_t            r;
    qph_pkg::rsp_t            none;
    logic [qph_pkg::CfgW-1:0] sz;
    int unsigned              n;
    int unsigned              p;
    int unsigned              q;
    int unsigned              sent;
    int unsigned              phase;
    int unsigned              items;

    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    cur_typed = 1'b0;
    cur_typed_rsp = '0;
    no_idle = 1'b0;
    hold_out = 1'b0;
    none = '0;
    for (int i = 0; i < qph_pkg::TableDepth; i++) slot_used[i] = 1'b0;
    repeat (5) @(negedge clk);
    rst = 1'b0;

    // reset size 997: empty table, key and value extremes, a collision chain
    plan_op(qph_pkg::OP_LOOKUP, 32'h0, 32'h0, 1'b1, qph_pkg::ST_NOT_FOUND, 32'h0);
    plan_op(qph_pkg::OP_INSERT, 32'h0, 32'h0, 1'b1, qph_pkg::ST_INSERTED, 32'h0);
    plan_op(qph_pkg::OP_INSERT, 32'h0, 32'hFFFF_FFFF, 1'b1, qph_pkg::ST_DUPLICATE, 32'h0);
    plan_op(qph_pkg::OP_LOOKUP, 32'h0, 32'h0, 1'b1, qph_pkg::ST_FOUND, 32'h0);
    plan_op(qph_pkg::OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, qph_pkg::ST_INSERTED,
            32'h0);
    plan_op(qph_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 32'h0, 1'b1, qph_pkg::ST_FOUND, 32'hFFFF_FFFF);
    plan_pred(qph_pkg::OP_INSERT, 32'd997, 32'hA5A5_A5A5);
    plan_pred(qph_pkg::OP_INSERT, 32'd1994, 32'h5A5A_5A5A);
    plan_pred(qph_pkg::OP_LOOKUP, 32'd1994, 32'h0);
    plan_pred(qph_pkg::OP_LOOKUP, 32'd2991, 32'h0);
    plan_op(OP_UNUSED, 32'h0, 32'hFFFF_FFFF, 1'b1, qph_pkg::ST_NOT_FOUND, 32'h0);
    plan_op(qph_pkg::OP_CLEAR, 32'h0, 32'h0, 1'b1, qph_pkg::ST_CLEARED, 32'h0);
    plan_op(qph_pkg::OP_LOOKUP, 32'h0, 32'h0, 1'b1, qph_pkg::ST_NOT_FOUND, 32'h0);
    // smallest table: fills after two keys
    plan_cfg(qph_pkg::CfgW'(2));
    plan_op(qph_pkg::OP_INSERT, 32'd4, 32'd1, 1'b1, qph_pkg::ST_INSERTED, 32'h0);
    plan_pred(qph_pkg::OP_INSERT, 32'd6, 32'd2);
    plan_op(qph_pkg::OP_INSERT, 32'd8, 32'd3, 1'b1, qph_pkg::ST_FULL, 32'h0);
    plan_pred(qph_pkg::OP_LOOKUP, 32'd6, 32'h0);
    plan_pred(qph_pkg::OP_LOOKUP, 32'd9, 32'h0);
    // out-of-range sizes clamp; resizing keeps old slots
    plan_cfg(qph_pkg::CfgW'(2047));
    plan_pred(qph_pkg::OP_INSERT, 32'd1024, 32'd7);
    plan_pred(qph_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 32'h0);
    plan_pred(qph_pkg::OP_LOOKUP, 32'd4, 32'h0);
    plan_cfg(qph_pkg::CfgW'(0));
    plan_pred(qph_pkg::OP_LOOKUP, 32'd1024, 32'h0);
    plan_pred(qph_pkg::OP_INSERT, 32'd3, 32'd9);
    plan_cfg(qph_pkg::CfgW'(1024));
    plan_pred(qph_pkg::OP_LOOKUP, 32'd6, 32'h0);
    plan_op(qph_pkg::OP_CLEAR, 32'h0, 32'h0, 1'b1, qph_pkg::ST_CLEARED, 32'h0);

    foreach (plan[i]) begin
      if (plan[i].is_cfg) write_size(plan[i].size);
      else send_item(plan[i].req, plan[i].typed, plan[i].rsp);
    end

    sent = 0;
    phase = 0;
    while (sent < RandomItems) begin
      case (phase)
        0: sz = qph_pkg::CfgW'(2);
        1: sz = qph_pkg::CfgW'(1024);
        2: sz = qph_pkg::CfgW'(0);
        3: sz = qph_pkg::CfgW'(2047);
        4: sz = qph_pkg::CfgW'(997);
        default: begin
          p = $urandom_range(0, 99);
          if (p < 60) sz = qph_pkg::CfgW'($urandom_range(2, 67));
          else if (p < 80) sz = qph_pkg::CfgW'($urandom_range(68, 1024));
          else if (p < 90) sz = qph_pkg::CfgW'($urandom_range(0, 1));
          else sz = qph_pkg::CfgW'($urandom_range(1025, 2047));
        end
      endcase
      write_size(sz);
      n = clamp_size(sz);
      no_idle = ($urandom_range(0, 3) == 0);
      items = $urandom_range(40, 70);
      for (int j = 0; j < items; j++) begin
        p = $urandom_range(0, 99);
        if (p < 2) r.operation = qph_pkg::OP_CLEAR;
        else if (p < 4) r.operation = OP_UNUSED;
        else if (p < 55) r.operation = qph_pkg::OP_INSERT;
        else r.operation = qph_pkg::OP_LOOKUP;
        q = $urandom_range(0, 99);
        if (q < 30 && key_pool.size() != 0)
          r.key = key_pool[$urandom_range(0, key_pool.size() - 1)];
        else if (q < 55)
          r.key = $urandom_range(0, 3) + n * $urandom_range(0, 4000);
        else
          r.key = $urandom();
        r.value = $urandom();
        if (r.operation == qph_pkg::OP_INSERT) begin
          key_pool.push_back(r.key);
          if (key_pool.size() > 64) void'(key_pool.pop_front());
        end
        send_item(r, 1'b0, none);
        // once: stall the result side while beats keep coming
        if (phase == 2 && j == 5) hold_out = 1'b1;
      end
      sent += items;
      phase++;
    end

    @(negedge clk);
    in_valid = 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("%0d result beats checked over %0d size writes", beats_checked, sizes_written);
    $display("inserted %0d, duplicate %0d, full %0d, found %0d, not found %0d, cleared %0d",
             status_seen[qph_pkg::ST_INSERTED], status_seen[qph_pkg::ST_DUPLICATE],
             status_seen[qph_pkg::ST_FULL], status_seen[qph_pkg::ST_FOUND],
             status_seen[qph_pkg::ST_NOT_FOUND], status_seen[qph_pkg::ST_CLEARED]);
    if (bad_count == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
